// ===== src/assert_macros.svh =====
// Assertion macros used by the pool back end; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define URDP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("urdp assertion failed");
`define URDP_NEVER(label, clk, rst_n, cond) \
    `URDP_ASSERT(label, clk, rst_n, !(cond))
`else
`define URDP_ASSERT(label, clk, rst_n, prop)
`define URDP_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== src/urdp_pkg.sv =====
// Shared widths, register indexes and state type of the draw pool.
package urdp_pkg;

    localparam int DEF_POOL_DEPTH = 256;

    localparam int WORD_W     = 31;
    localparam int STEP_W     = 5;
    localparam int BASE_W     = 16;
    localparam int SPAN_W     = 8;
    localparam int DRAWN_W    = 17;
    localparam int LEFT_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SPAN  = 2'd1;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 8'hFF;

    typedef enum logic [2:0] {
        B_SWEEP,
        B_IDLE,
        B_DIV,
        B_RD_SLOT,
        B_RD_LAST,
        B_WR_SLOT,
        B_WR_LAST,
        B_EMIT
    } back_state_t;

endpackage

// ===== src/urdp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module urdp_ram import urdp_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEF_POOL_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/urdp_queue.sv =====
// Short FIFO that carries classified items from the front to the back.
module urdp_queue import urdp_pkg::*; #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop,
    output logic [W-1:0] pop_data
);

    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QFILL_W-1:0] fill_reg, fill_next;
    logic               do_push, do_pop;

    assign push_ready = (fill_reg != QFILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + QFILL_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - QFILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/urdp_front.sv =====
// Front end: configuration registers, live count and item classification.
module urdp_front import urdp_pkg::*; #(
    parameter int POOL_DEPTH = DEF_POOL_DEPTH,
    parameter int AW         = $clog2(POOL_DEPTH),
    parameter int CW         = $clog2(POOL_DEPTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [WORD_W-1:0]       s_word,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    sweeping,
    input  logic                    q_ready,
    output logic                    q_valid,
    output logic [WORD_W+CW:0]      q_data,
    output logic                    refill_req,
    output logic [BASE_W-1:0]       base_value,
    output logic [AW-1:0]           eff_span
);

    localparam int EW = (AW > SPAN_W) ? AW : SPAN_W;

    logic [BASE_W-1:0] base_reg, base_next;
    logic [SPAN_W-1:0] span_reg, span_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              cfg_wr, cfg_hit, accept, exh;
    logic [CW-1:0]     item_cnt;

    // clamp the span to the pool depth minus one
    function automatic logic [AW-1:0] eff_of(input logic [SPAN_W-1:0] s);
        logic [EW-1:0] se;
        logic [EW-1:0] lim;
        se  = EW'(s);
        lim = EW'(POOL_DEPTH - 1);
        return (se > lim) ? AW'(lim) : AW'(se);
    endfunction

    function automatic logic [CW-1:0] total_of(input logic [SPAN_W-1:0] s);
        return CW'(eff_of(s)) + CW'(1);
    endfunction

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign cfg_hit    = cfg_wr && (cfg_index == REG_BASE_VALUE || cfg_index == REG_POOL_SPAN);
    assign refill_req = cfg_hit;

    assign s_tready = q_ready && !sweeping;
    assign accept   = s_tvalid && s_tready;
    assign exh      = (count_reg == '0);
    assign item_cnt = exh ? total_of(span_reg) : count_reg;

    assign q_valid = s_tvalid && !sweeping;
    assign q_data  = {exh, item_cnt, s_word};

    assign base_value = base_reg;
    assign eff_span   = eff_of(span_reg);

    always_comb begin
        base_next  = base_reg;
        span_next  = span_reg;
        count_next = count_reg;
        if (cfg_wr && cfg_index == REG_BASE_VALUE) begin
            base_next = cfg_data[BASE_W-1:0];
        end
        if (cfg_wr && cfg_index == REG_POOL_SPAN) begin
            span_next = cfg_data[SPAN_W-1:0];
        end
        if (cfg_hit) begin
            count_next = total_of(span_next);
        end else if (accept) begin
            // an empty pool refills to the full count
            count_next = exh ? total_of(span_reg) : count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            span_reg  <= SPAN_RESET;
            count_reg <= total_of(SPAN_RESET);
        end else begin
            base_reg  <= base_next;
            span_reg  <= span_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/urdp_back.sv =====
// Back end: slot modulo, pool swap, refill sweep and result register.
`include "assert_macros.svh"
module urdp_back import urdp_pkg::*; #(
    parameter int POOL_DEPTH = DEF_POOL_DEPTH,
    parameter int AW         = $clog2(POOL_DEPTH),
    parameter int CW         = $clog2(POOL_DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  logic [WORD_W+CW:0]   q_data,
    input  logic                 refill_req,
    input  logic [BASE_W-1:0]    base_value,
    input  logic [AW-1:0]        eff_span,
    output logic                 sweeping,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DRAWN_W-1:0]   drawn_value,
    output logic                 exhausted,
    output logic [LEFT_W-1:0]    left_after
);

    back_state_t state_reg, state_next;

    logic [WORD_W-1:0]  word_reg;
    logic [CW-1:0]      cnt_reg;
    logic               exh_reg;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg;
    logic [AW-1:0]      pick_reg;
    logic [AW-1:0]      sweep_idx_reg;

    logic               out_valid_reg;
    logic [DRAWN_W-1:0] out_drawn_reg;
    logic               out_exh_reg;
    logic [LEFT_W-1:0]  out_left_reg;

    logic               out_free, load_out;
    logic [CW:0]        rem_trial, div_ext;
    logic [AW-1:0]      slot_addr, last_addr;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr, ram_wdata, ram_rdata;

    assign out_free  = !out_valid_reg || m_tready;
    assign slot_addr = AW'(rem_reg);
    assign last_addr = AW'(cnt_reg - CW'(1));

    // one restoring step per quotient bit
    assign rem_trial = {rem_reg, word_reg[WORD_W-1]};
    assign div_ext   = {1'b0, cnt_reg};
    assign rem_next  = (rem_trial >= div_ext) ? CW'(rem_trial - div_ext) : rem_trial[CW-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_SWEEP: begin
                if (sweep_idx_reg == eff_span) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (q_valid) begin
                    state_next = q_data[WORD_W+CW] ? B_EMIT : B_DIV;
                end
            end
            B_DIV: begin
                if (step_reg == STEP_W'(WORD_W - 1)) begin
                    state_next = B_RD_SLOT;
                end
            end
            B_RD_SLOT: state_next = B_RD_LAST;
            B_RD_LAST: state_next = B_WR_SLOT;
            B_WR_SLOT: state_next = B_WR_LAST;
            B_WR_LAST: state_next = B_EMIT;
            B_EMIT: begin
                if (out_free) begin
                    state_next = exh_reg ? B_SWEEP : B_IDLE;
                end
            end
            default: state_next = B_SWEEP;
        endcase
        if (refill_req) begin
            state_next = B_SWEEP;
        end
    end

    always_comb begin
        q_pop     = 1'b0;
        load_out  = 1'b0;
        sweeping  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = sweep_idx_reg;
        ram_wdata = sweep_idx_reg;
        ram_raddr = slot_addr;
        case (state_reg)
            B_SWEEP: begin
                sweeping = 1'b1;
                ram_we   = 1'b1;
            end
            B_IDLE:    q_pop = q_valid;
            B_RD_LAST: ram_raddr = last_addr;
            B_WR_SLOT: begin
                // the last live entry moves into the drawn slot
                ram_we    = 1'b1;
                ram_waddr = slot_addr;
                ram_wdata = ram_rdata;
            end
            B_WR_LAST: begin
                ram_we    = 1'b1;
                ram_waddr = last_addr;
                ram_wdata = pick_reg;
            end
            B_EMIT:  load_out = out_free;
            default: q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_SWEEP;
            sweep_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (refill_req || (load_out && exh_reg)) begin
                sweep_idx_reg <= '0;
            end else if (state_reg == B_SWEEP) begin
                sweep_idx_reg <= sweep_idx_reg + AW'(1);
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            word_reg <= q_data[WORD_W-1:0];
            cnt_reg  <= q_data[WORD_W+CW-1:WORD_W];
            exh_reg  <= q_data[WORD_W+CW];
            rem_reg  <= '0;
            step_reg <= '0;
        end else if (state_reg == B_DIV) begin
            rem_reg  <= rem_next;
            word_reg <= {word_reg[WORD_W-2:0], 1'b0};
            step_reg <= step_reg + STEP_W'(1);
        end
        if (state_reg == B_RD_LAST) begin
            pick_reg <= ram_rdata;
        end
        if (load_out) begin
            out_exh_reg <= exh_reg;
            if (exh_reg) begin
                out_drawn_reg <= DRAWN_W'(base_value);
                out_left_reg  <= LEFT_W'(cnt_reg);
            end else begin
                out_drawn_reg <= DRAWN_W'(base_value) + DRAWN_W'(pick_reg);
                out_left_reg  <= LEFT_W'(cnt_reg - CW'(1));
            end
        end
    end

    urdp_ram #(
        .WIDTH (AW),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid    = out_valid_reg;
    assign drawn_value = out_drawn_reg;
    assign exhausted   = out_exh_reg;
    assign left_after  = out_left_reg;

    `URDP_ASSERT(a_div_steps, aclk, aresetn, (state_reg == B_DIV) |-> (step_reg <= STEP_W'(WORD_W - 1)))
    `URDP_ASSERT(a_slot_live, aclk, aresetn, (state_reg == B_RD_SLOT) |-> (rem_reg < cnt_reg))
    `URDP_ASSERT(a_sweep_bound, aclk, aresetn, (state_reg == B_SWEEP) |-> (sweep_idx_reg <= eff_span))
    `URDP_ASSERT(a_refill_sweep, aclk, aresetn, refill_req |=> (state_reg == B_SWEEP && sweep_idx_reg == '0))

endmodule

// ===== src/unique_random_draw_pool.sv =====
// Top level of the draw-without-replacement pool.
//
//  channel  | direction | handshake               | content
//  ---------+-----------+-------------------------+--------------------------------------
//  s_*      | in        | s_tvalid / s_tready     | random word per draw
//  m_*      | out       | m_tvalid / m_tready     | drawn value, count left, exhausted flag
//  cfg_*    | in        | cfg_valid / cfg_ready   | register index and write data
//
// A draw picks up the item, runs 31 steps of the bit-serial remainder by the
// live count, takes four steps on the single pool RAM port pair for the swap,
// then loads the result register once it is free.
// An exhausted draw goes straight from pick-up to the result register, then sweeps
// entries 0 to the effective span back to identity; input is held off meanwhile.
// Reset and every write to a defined register run the same sweep.
// The front keeps taking items into a two-entry queue while the back works
// or its result waits on m_tready.
module unique_random_draw_pool import urdp_pkg::*; #(
    parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // [30:0] random_word, [31] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // [16:0] drawn_value, [25:17] left_after, [31:26] zero
    output logic                  m_tuser,    // [0] exhausted
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);

    logic                 sweeping, refill_req;
    logic                 q_in_valid, q_in_ready, q_out_valid, q_pop;
    logic [WORD_W+CW:0]   q_in_data, q_out_data;
    logic [BASE_W-1:0]    base_value;
    logic [AW-1:0]        eff_span;
    logic [DRAWN_W-1:0]   drawn_value;
    logic [LEFT_W-1:0]    left_after;
    logic                 exhausted;

    urdp_front #(
        .POOL_DEPTH (POOL_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_word     (s_tdata[WORD_W-1:0]),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sweeping   (sweeping),
        .q_ready    (q_in_ready),
        .q_valid    (q_in_valid),
        .q_data     (q_in_data),
        .refill_req (refill_req),
        .base_value (base_value),
        .eff_span   (eff_span)
    );

    urdp_queue #(
        .W (WORD_W + CW + 1)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data),
        .pop_valid  (q_out_valid),
        .pop        (q_pop),
        .pop_data   (q_out_data)
    );

    urdp_back #(
        .POOL_DEPTH (POOL_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_out_valid),
        .q_pop       (q_pop),
        .q_data      (q_out_data),
        .refill_req  (refill_req),
        .base_value  (base_value),
        .eff_span    (eff_span),
        .sweeping    (sweeping),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .drawn_value (drawn_value),
        .exhausted   (exhausted),
        .left_after  (left_after)
    );

    assign m_tdata = {(M_TDATA_W - DRAWN_W - LEFT_W)'(0), left_after, drawn_value};
    assign m_tuser = exhausted;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the unique random draw pool: stream stimulus, scoreboard, config.
module tb_top;
    import urdp_pkg::*;

    localparam int POOL_DEPTH   = DEF_POOL_DEPTH;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int SETTLE_WAIT  = 300;

    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [WORD_W-1:0] WORD_MAX = '1;

    typedef struct packed {
        logic [DRAWN_W-1:0] drawn;
        logic               exhausted;
        logic [LEFT_W-1:0]  left;
    } draw_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow of the pool: offsets, live count and registers
    logic [SPAN_W-1:0] pool_offsets [POOL_DEPTH];
    logic [LEFT_W-1:0] live_count;
    logic [BASE_W-1:0] base_cfg;
    logic [SPAN_W-1:0] span_cfg;

    logic [WORD_W-1:0] pending_words[$];
    draw_t             expected_draws[$];

    int errors        = 0;
    int words_queued  = 0;
    int draws_checked = 0;
    int empty_draws   = 0;
    int reg_writes    = 0;
    int cycle_count   = 0;
    int gap_pct       = 0;
    int stall_pct     = 0;
    int gap_left      = 0;
    int burst_left    = 1;
    int stall_left    = 0;

    unique_random_draw_pool dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void refill_pool();
        for (int i = 0; i < POOL_DEPTH; i++)
            pool_offsets[i] = SPAN_W'(i);
        // clamp span to the pool depth minus one
        if (int'(span_cfg) > POOL_DEPTH - 1)
            live_count = LEFT_W'(POOL_DEPTH);
        else
            live_count = LEFT_W'(int'(span_cfg) + 1);
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_BASE_VALUE: begin
                base_cfg = data[BASE_W-1:0];
                refill_pool();
            end
            REG_POOL_SPAN: begin
                span_cfg = data[SPAN_W-1:0];
                refill_pool();
            end
            default: ;
        endcase
    endfunction

    function automatic draw_t predict_draw(input logic [WORD_W-1:0] word);
        draw_t             r;
        int unsigned       slot;
        int unsigned       last;
        logic [SPAN_W-1:0] pick;
        r = '0;
        if (live_count != 0 && int'(live_count) <= POOL_DEPTH) begin
            slot = word % live_count;
            last = live_count - 1;
            pick = pool_offsets[slot];
            r.drawn = DRAWN_W'(base_cfg) + DRAWN_W'(pick);
            // swap the chosen slot with the last live entry
            pool_offsets[slot] = pool_offsets[last];
            pool_offsets[last] = pick;
            live_count = LEFT_W'(last);
        end else begin
            r.drawn = DRAWN_W'(base_cfg);
            r.exhausted = 1'b1;
            refill_pool();
        end
        r.left = live_count;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return '0;
            1:       return WORD_MAX;
            2:       return WORD_W'($urandom_range(0, 1000));
            default: return WORD_W'($urandom);
        endcase
    endfunction

    task automatic queue_word(input logic [WORD_W-1:0] word);
        pending_words.push_back(word);
        words_queued++;
    endtask

    // Hold until every queued item has come back as a result
    task automatic wait_drained();
        while (draws_checked < words_queued)
            @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, data);
        reg_writes++;
    endtask

    function automatic int pick_pct();
        int sel;
        sel = $urandom_range(0, 2);
        case (sel)
            0:       return 0;
            1:       return 25;
            default: return 60;
        endcase
    endfunction

    // Driver: feed pending items in bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_draws.push_back(predict_draw(s_tdata[WORD_W-1:0]));
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    s_tdata  <= S_TDATA_W'(pending_words.pop_front());
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 12) : 0;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expectation, stall at random
    always @(posedge aclk) begin : monitor_blk
        draw_t got;
        draw_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.drawn     = m_tdata[DRAWN_W-1:0];
                got.exhausted = m_tuser;
                got.left      = m_tdata[DRAWN_W +: LEFT_W];
                if (expected_draws.size() == 0) begin
                    $display("%0t: unexpected result drawn=%0d exhausted=%0b left=%0d",
                             $time, got.drawn, got.exhausted, got.left);
                    errors++;
                end else begin
                    want = expected_draws.pop_front();
                    if (got.drawn !== want.drawn) begin
                        $display("%0t: drawn_value expected %0d actual %0d",
                                 $time, want.drawn, got.drawn);
                        errors++;
                    end
                    if (got.exhausted !== want.exhausted) begin
                        $display("%0t: exhausted expected %0b actual %0b",
                                 $time, want.exhausted, got.exhausted);
                        errors++;
                    end
                    if (got.left !== want.left) begin
                        $display("%0t: left_after expected %0d actual %0d",
                                 $time, want.left, got.left);
                        errors++;
                    end
                    if (want.exhausted)
                        empty_draws++;
                end
                draws_checked++;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, 6);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d of %0d items checked",
                     cycle_count, draws_checked, words_queued);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int                    random_count;
        int                    n;
        int                    sel;
        logic [SPAN_W-1:0]     span_pick;
        logic [BASE_W-1:0]     base_pick;
        logic                  first_phase;
        base_cfg = '0;
        span_cfg = SPAN_RESET;
        refill_pool();
        random_count = 0;
        first_phase  = 1'b1;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset state: full span, word extremes and alternating bits
        queue_word('0);
        queue_word(WORD_MAX);
        queue_word(WORD_W'(1));
        queue_word(WORD_W'(32'h4000_0000));
        queue_word(WORD_W'(32'h2AAA_AAAA));
        queue_word(WORD_W'(32'h5555_5555));
        wait_drained();

        // Top base, span zero with upper data bits set (masked away)
        write_register(REG_BASE_VALUE, 16'hFFFF);
        write_register(REG_POOL_SPAN, 16'hFF00);
        queue_word(WORD_MAX);
        queue_word('0);
        queue_word(WORD_W'(5));
        wait_drained();

        // Writes to unused indexes must not refill a partly drawn pool
        write_register(REG_POOL_SPAN, 16'h0003);
        queue_word(WORD_W'(3));
        queue_word(WORD_MAX);
        wait_drained();
        write_register(REG_SPARE_A, 16'hFFFF);
        write_register(REG_SPARE_B, 16'h0001);
        queue_word('0);
        queue_word(WORD_W'(1));
        queue_word(WORD_W'(2));
        queue_word(WORD_W'(7));
        wait_drained();

        write_register(REG_BASE_VALUE, 16'h0000);
        queue_word(WORD_W'(9));
        wait_drained();

        while (random_count < RANDOM_ITEMS) begin
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
            sel = $urandom_range(0, 9);
            base_pick = (sel == 0) ? 16'h0000 :
                        (sel == 1) ? 16'hFFFF : BASE_W'($urandom);
            if (first_phase) begin
                // one full-depth pass through exhaustion
                first_phase = 1'b0;
                write_register(REG_BASE_VALUE, base_pick);
                write_register(REG_POOL_SPAN, {8'hA5, 8'hFF});
                n = POOL_DEPTH + 6;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 50)
                    span_pick = SPAN_W'($urandom_range(0, 7));
                else if (sel < 85)
                    span_pick = SPAN_W'($urandom_range(8, 40));
                else if (sel < 95)
                    span_pick = SPAN_W'($urandom_range(41, 254));
                else
                    span_pick = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                if ($urandom_range(0, 99) < 50)
                    write_register(REG_BASE_VALUE, base_pick);
                if ($urandom_range(0, 99) < 60)
                    write_register(REG_POOL_SPAN,
                                   {8'($urandom_range(0, 255)), span_pick});
                if ($urandom_range(0, 99) < 20)
                    write_register(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                                   CFG_DATA_W'($urandom));
                n = $urandom_range(4, 2 * (int'(span_cfg) + 1) + 3);
                if (n > 120)
                    n = 120;
            end
            for (int k = 0; k < n; k++)
                queue_word(pick_word());
            random_count += n;
            wait_drained();
        end

        // Let any sweep finish and catch stray results
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (expected_draws.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_draws.size());
            errors++;
        end

        $display("Checked %0d draws (%0d on an empty pool) across %0d register writes.",
                 draws_checked, empty_draws, reg_writes);
        $display("Spans 0 to 255, bases at both ends, unused indexes, bursty input, stalled output.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
